[hdl/ple_pkg.sv]
// ----------------------------------------------------------------------------
// ple_pkg
// Shared types and constants for the positional list engine: beat payloads,
// command and status codes, controller states and controller/datapath links.
// ----------------------------------------------------------------------------
package ple_pkg;

   localparam int unsigned VALUE_W = 32;
   localparam int unsigned POS_W   = 5;
   localparam int unsigned LEN_W   = 5;

   typedef enum logic [1:0] {
      CMD_INSERT = 2'd0,
      CMD_DELETE = 2'd1,
      CMD_SEARCH = 2'd2,
      CMD_READ   = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      STS_DONE  = 2'd0,
      STS_FULL  = 2'd1,
      STS_EMPTY = 2'd2,
      STS_RANGE = 2'd3
   } status_type;

   typedef struct packed {
      cmd_type                    command;
      logic signed [VALUE_W-1:0]  value;
      logic        [POS_W-1:0]    position;
   } req_type;

   typedef struct packed {
      status_type                 status;
      logic                       found;
      logic signed [VALUE_W-1:0]  read_value;
      logic        [LEN_W-1:0]    length;
   } rsp_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_CHECK,
      S_INS_TEST,
      S_INS_MOVE,
      S_DEL_TEST,
      S_DEL_MOVE,
      S_SRC_TEST,
      S_SRC_CMP,
      S_RD_FETCH,
      S_RD_CAP,
      S_FINISH
   } state_type;

   // memory read address source
   typedef enum logic [1:0] {
      RA_IDX  = 2'd0,
      RA_PREV = 2'd1,
      RA_NEXT = 2'd2
   } rd_sel_type;

   // memory write data source
   typedef enum logic {
      WD_VALUE = 1'b0,
      WD_SHIFT = 1'b1
   } wr_sel_type;

   typedef struct packed {
      logic       accept;
      logic       check;
      logic       idx_init;
      logic       idx_inc;
      logic       idx_dec;
      logic       mem_rd;
      rd_sel_type rd_sel;
      logic       mem_wr;
      wr_sel_type wr_sel;
      logic       count_inc;
      logic       count_dec;
      logic       set_found;
      logic       cap_read;
      logic       load_rsp;
   } ctl_type;

   typedef struct packed {
      cmd_type cmd;
      logic    bad;
      logic    ins_more;
      logic    del_more;
      logic    src_more;
      logic    hit;
      logic    out_free;
   } stat_type;

endpackage

[hdl/ple_ctrl.sv]
// ----------------------------------------------------------------------------
// ple_ctrl
// Command sequencer: accepts a beat, checks it, steps the datapath through
// the shift, scan or read loop and hands the result to the output register.
// ----------------------------------------------------------------------------
module ple_ctrl import ple_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_stall,
   input  stat_type stat,
   output ctl_type  ctl
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      ctl       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               ctl.accept = 1'b1;
               state_in   = S_CHECK;
            end
         end
         S_CHECK: begin
            ctl.check    = 1'b1;
            ctl.idx_init = 1'b1;
            if (stat.bad) begin
               state_in = S_FINISH;
            end else begin
               unique case (stat.cmd)
                  CMD_INSERT: state_in = S_INS_TEST;
                  CMD_DELETE: state_in = S_DEL_TEST;
                  CMD_SEARCH: state_in = S_SRC_TEST;
                  CMD_READ:   state_in = S_RD_FETCH;
                  default:    state_in = S_FINISH;
               endcase
            end
         end
         S_INS_TEST: begin
            if (stat.ins_more) begin
               // fetch the entry that moves back by one
               ctl.mem_rd = 1'b1;
               ctl.rd_sel = RA_PREV;
               state_in   = S_INS_MOVE;
            end else begin
               ctl.mem_wr    = 1'b1;
               ctl.wr_sel    = WD_VALUE;
               ctl.count_inc = 1'b1;
               state_in      = S_FINISH;
            end
         end
         S_INS_MOVE: begin
            ctl.mem_wr  = 1'b1;
            ctl.wr_sel  = WD_SHIFT;
            ctl.idx_dec = 1'b1;
            state_in    = S_INS_TEST;
         end
         S_DEL_TEST: begin
            if (stat.del_more) begin
               ctl.mem_rd = 1'b1;
               ctl.rd_sel = RA_NEXT;
               state_in   = S_DEL_MOVE;
            end else begin
               ctl.count_dec = 1'b1;
               state_in      = S_FINISH;
            end
         end
         S_DEL_MOVE: begin
            ctl.mem_wr  = 1'b1;
            ctl.wr_sel  = WD_SHIFT;
            ctl.idx_inc = 1'b1;
            state_in    = S_DEL_TEST;
         end
         S_SRC_TEST: begin
            if (stat.src_more) begin
               ctl.mem_rd = 1'b1;
               ctl.rd_sel = RA_IDX;
               state_in   = S_SRC_CMP;
            end else begin
               state_in = S_FINISH;
            end
         end
         S_SRC_CMP: begin
            if (stat.hit) begin
               ctl.set_found = 1'b1;
               state_in      = S_FINISH;
            end else begin
               ctl.idx_inc = 1'b1;
               state_in    = S_SRC_TEST;
            end
         end
         S_RD_FETCH: begin
            ctl.mem_rd = 1'b1;
            ctl.rd_sel = RA_IDX;
            state_in   = S_RD_CAP;
         end
         S_RD_CAP: begin
            ctl.cap_read = 1'b1;
            state_in     = S_FINISH;
         end
         S_FINISH: begin
            if (stat.out_free) begin
               ctl.load_rsp = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

[hdl/ple_datapath.sv]
// ----------------------------------------------------------------------------
// ple_datapath
// Entry memory, length counter, walk index, command checks and the result
// register. Driven step by step by the controller.
// ----------------------------------------------------------------------------
module ple_datapath import ple_pkg::*; #(
   parameter int CAPACITY = 16
) (
   input  logic     clock,
   input  logic     reset,
   input  req_type  req_data,
   input  ctl_type  ctl,
   output stat_type stat,
   output logic     rsp_valid,
   input  logic     rsp_stall,
   output rsp_type  rsp_data
);

   localparam int CW = $clog2(CAPACITY + 1);
   localparam int AW = $clog2(CAPACITY);
   localparam int PW = (CW > POS_W) ? CW : POS_W;
   localparam int XW = PW + 1;

   logic [VALUE_W-1:0] mem [CAPACITY];

   req_type            req_ff;
   logic [CW-1:0]      count_ff, count_in;
   logic [CW-1:0]      idx_ff, idx_in;
   status_type         status_ff, status_in;
   logic               found_ff;
   logic [VALUE_W-1:0] rdval_ff;
   logic [VALUE_W-1:0] rdata_ff;
   rsp_type            rsp_ff;
   logic               rsp_valid_ff, rsp_valid_in;

   logic [XW-1:0]      cnt_x, pos_x, idx_x;
   logic [CW-1:0]      idx_prev, idx_next;
   logic [AW-1:0]      rd_addr, wr_addr;
   logic [VALUE_W-1:0] wr_data;

   assign cnt_x    = XW'(count_ff);
   assign pos_x    = XW'(req_ff.position);
   assign idx_x    = XW'(idx_ff);
   assign idx_prev = idx_ff - CW'(1);
   assign idx_next = idx_ff + CW'(1);

   // full is checked before position, empty before position
   always_comb begin
      status_in = STS_DONE;
      unique case (req_ff.command) inside
         CMD_INSERT: begin
            if (cnt_x >= XW'(CAPACITY)) begin
               status_in = STS_FULL;
            end else if (pos_x == '0 || pos_x > cnt_x + XW'(1)) begin
               status_in = STS_RANGE;
            end
         end
         CMD_SEARCH: begin
            if (cnt_x == '0) begin
               status_in = STS_EMPTY;
            end
         end
         CMD_DELETE, CMD_READ: begin
            if (cnt_x == '0) begin
               status_in = STS_EMPTY;
            end else if (pos_x == '0 || pos_x > cnt_x) begin
               status_in = STS_RANGE;
            end
         end
         default: begin
            status_in = STS_DONE;
         end
      endcase
   end

   always_comb begin
      idx_in = idx_ff;
      if (ctl.idx_init) begin
         case (req_ff.command)
            CMD_INSERT: idx_in = count_ff;
            CMD_SEARCH: idx_in = '0;
            default:    idx_in = CW'(pos_x - XW'(1));
         endcase
      end else if (ctl.idx_inc) begin
         idx_in = idx_next;
      end else if (ctl.idx_dec) begin
         idx_in = idx_prev;
      end
   end

   always_comb begin
      count_in = count_ff;
      if (ctl.count_inc) begin
         count_in = count_ff + CW'(1);
      end else if (ctl.count_dec) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_comb begin
      case (ctl.rd_sel)
         RA_PREV: rd_addr = idx_prev[AW-1:0];
         RA_NEXT: rd_addr = idx_next[AW-1:0];
         default: rd_addr = idx_ff[AW-1:0];
      endcase
   end

   assign wr_addr = idx_ff[AW-1:0];
   assign wr_data = (ctl.wr_sel == WD_SHIFT) ? rdata_ff : req_ff.value;

   always_ff @(posedge clock) begin
      if (ctl.mem_wr) begin
         mem[wr_addr] <= wr_data;
      end
      if (ctl.mem_rd) begin
         rdata_ff <= mem[rd_addr];
      end
   end

   assign rsp_valid_in = ctl.load_rsp ? 1'b1 : (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      if (ctl.accept) begin
         req_ff   <= req_data;
         found_ff <= 1'b0;
         rdval_ff <= '0;
      end
      if (ctl.check) begin
         status_ff <= status_in;
      end
      if (ctl.set_found) begin
         found_ff <= 1'b1;
      end
      if (ctl.cap_read) begin
         rdval_ff <= rdata_ff;
      end
      if (ctl.load_rsp) begin
         rsp_ff.status     <= status_ff;
         rsp_ff.found      <= found_ff;
         rsp_ff.read_value <= rdval_ff;
         rsp_ff.length     <= LEN_W'(count_ff);
      end
   end

   assign stat.cmd      = req_ff.command;
   assign stat.bad      = (status_in != STS_DONE);
   assign stat.ins_more = (idx_x >= pos_x);
   assign stat.del_more = (idx_x + XW'(1) < cnt_x);
   assign stat.src_more = (idx_x < cnt_x);
   assign stat.hit      = (rdata_ff == req_ff.value);
   assign stat.out_free = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY))
      else $error("list length above capacity");

   a_count_cmd: assert property (@(posedge clock) disable iff (reset)
      !$stable(count_ff) |-> $past(ctl.count_inc || ctl.count_dec || reset))
      else $error("list length changed without insert or delete");

   a_wr_addr: assert property (@(posedge clock) disable iff (reset)
      ctl.mem_wr |-> (XW'(wr_addr) < XW'(CAPACITY)))
      else $error("entry write beyond capacity");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      ctl.count_inc |-> (count_ff < CW'(CAPACITY)))
      else $error("insert into a full list");

endmodule

[hdl/positional_list_engine.sv]
// ----------------------------------------------------------------------------
// positional_list_engine
// Ordered list of up to CAPACITY signed words with insert at position,
// delete at position, search and read; one result beat per command beat.
// Entries sit in one memory that the sequencer reads and writes in separate
// steps, so one command is worked on at a time; each entry that is moved
// or compared takes one memory read then one memory write or compare.
// Rejected commands (full, empty, out of range) skip the loops. The result
// register lets a new command be taken while the previous result is stalled.
// No clearing pass is needed after reset; length restarts at zero.
// ----------------------------------------------------------------------------
module positional_list_engine import ple_pkg::*; #(
   parameter int CAPACITY = 16
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   ctl_type  ctl;
   stat_type stat;

   ple_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .ctl       (ctl)
   );

   ple_datapath #(
      .CAPACITY (CAPACITY)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .ctl       (ctl),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

[tb/list_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// list_checker
// Watches the command and result channels of the positional list engine,
// keeps its own copy of the list, works out the result of every accepted
// command beat and compares each result beat field by field, in order.
// ----------------------------------------------------------------------------
module list_checker import ple_pkg::*; #(
   parameter int CAPACITY = 16
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_stall,
   input  req_type req_data,
   input  logic    rsp_valid,
   input  logic    rsp_stall,
   input  rsp_type rsp_data,
   output int      errors,
   output int      pending,
   output int      fill
);

   logic signed [VALUE_W-1:0] list_words [CAPACITY];
   int                        list_len;
   rsp_type                   results_due [$];
   rsp_type                   want;

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] exp_val);
      errors++;
      if (errors <= 60)
         $display("%0t mismatch in %s: got %h, want %h", $realtime, what, got, exp_val);
   endtask

   // updates the list copy and returns the result the engine must give
   function automatic rsp_type apply_list_command(input req_type cmd);
      rsp_type r;
      int      p;
      int      i;
      r = '0;
      r.status = STS_DONE;
      p = int'(cmd.position);
      case (cmd.command)
         CMD_INSERT: begin
            if (list_len >= CAPACITY) begin
               r.status = STS_FULL;
            end else if (p < 1 || p > list_len + 1) begin
               r.status = STS_RANGE;
            end else begin
               for (i = list_len; i > p - 1; i--)
                  list_words[i] = list_words[i-1];
               list_words[p-1] = cmd.value;
               list_len++;
            end
         end
         CMD_DELETE: begin
            if (list_len == 0) begin
               r.status = STS_EMPTY;
            end else if (p < 1 || p > list_len) begin
               r.status = STS_RANGE;
            end else begin
               for (i = p - 1; i + 1 < list_len; i++)
                  list_words[i] = list_words[i+1];
               list_len--;
            end
         end
         CMD_SEARCH: begin
            if (list_len == 0) begin
               r.status = STS_EMPTY;
            end else begin
               for (i = 0; i < list_len; i++)
                  if (list_words[i] == cmd.value)
                     r.found = 1'b1;
            end
         end
         default: begin
            if (list_len == 0) begin
               r.status = STS_EMPTY;
            end else if (p < 1 || p > list_len) begin
               r.status = STS_RANGE;
            end else begin
               r.read_value = list_words[p-1];
            end
         end
      endcase
      r.length = list_len[LEN_W-1:0];
      return r;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         results_due.delete();
         list_len = 0;
         errors = 0;
      end else begin
         // the result beat always belongs to an earlier command beat
         if (rsp_valid && !rsp_stall) begin
            if (results_due.size() == 0) begin
               report_mismatch("unexpected result beat", rsp_data.read_value, '0);
            end else begin
               want = results_due.pop_front();
               if (rsp_data.status !== want.status)
                  report_mismatch("status", 32'(rsp_data.status), 32'(want.status));
               if (rsp_data.found !== want.found)
                  report_mismatch("found", 32'(rsp_data.found), 32'(want.found));
               if (rsp_data.read_value !== want.read_value)
                  report_mismatch("read_value", rsp_data.read_value, want.read_value);
               if (rsp_data.length !== want.length)
                  report_mismatch("length", 32'(rsp_data.length), 32'(want.length));
            end
         end
         if (req_valid && !req_stall)
            results_due.push_back(apply_list_command(req_data));
      end
      pending = results_due.size();
      fill = list_len;
   end

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives the positional list engine with a directed opening and then random
// command beats that fill, mix and drain the list, with random gaps and
// result stalls; the list checker predicts and compares every result.
// ----------------------------------------------------------------------------
module testbench import ple_pkg::*; ();

   localparam int LIST_CAP     = 16;
   localparam int RANDOM_BEATS = 1680;
   localparam int QUIET_LIMIT  = 3000;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;

   int errors;
   int pending;
   int fill;
   int quiet_cycles;
   bit calm;

   logic signed [VALUE_W-1:0] hot_values [8];

   positional_list_engine #(.CAPACITY(LIST_CAP)) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   list_checker #(.CAPACITY(LIST_CAP)) u_checker (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .errors    (errors),
      .pending   (pending),
      .fill      (fill)
   );

   initial clock = 1'b0;
   always #2 clock = ~clock;

   always @(negedge clock) begin
      rsp_stall <= (reset || calm) ? 1'b0 : ($urandom_range(0, 99) < 31);
   end

   // ends the run when nothing moves on either channel for too long
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
         end
      end
   end

   task automatic send_command(input cmd_type c, input logic signed [VALUE_W-1:0] v,
                               input logic [POS_W-1:0] p);
      @(negedge clock);
      if (!calm) begin
         while ($urandom_range(0, 99) < 31) begin
            req_valid <= 1'b0;
            @(negedge clock);
         end
      end
      req_valid         <= 1'b1;
      req_data.command  <= c;
      req_data.value    <= v;
      req_data.position <= p;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
   endtask

   task automatic send_random(input int phase);
      int      roll;
      int      lo_len;
      cmd_type c;
      logic signed [VALUE_W-1:0] v;
      logic [POS_W-1:0] p;
      roll = $urandom_range(0, 99);
      // phase 0 grows the list, phase 2 shrinks it, the others mix
      if (phase == 0)
         c = (roll < 70) ? CMD_INSERT : (roll < 80) ? CMD_DELETE :
             (roll < 90) ? CMD_SEARCH : CMD_READ;
      else if (phase == 2)
         c = (roll < 10) ? CMD_INSERT : (roll < 80) ? CMD_DELETE :
             (roll < 90) ? CMD_SEARCH : CMD_READ;
      else
         c = (roll < 30) ? CMD_INSERT : (roll < 55) ? CMD_DELETE :
             (roll < 75) ? CMD_SEARCH : CMD_READ;
      if ($urandom_range(0, 1) == 0)
         v = hot_values[3'($urandom_range(0, 7))];
      else
         v = $urandom();
      roll = $urandom_range(0, 99);
      lo_len = (fill < 1) ? 1 : fill;
      if (roll < 85)
         p = (c == CMD_INSERT) ? POS_W'($urandom_range(1, fill + 1)) :
                                 POS_W'($urandom_range(1, lo_len));
      else if (roll < 90)
         p = '0;
      else
         p = POS_W'($urandom_range(0, 31));
      send_command(c, v, p);
   endtask

   initial begin
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      rsp_stall = 1'b0;
      calm      = 1'b0;
      hot_values[0] = 32'sh8000_0000;
      hot_values[1] = 32'sh7fff_ffff;
      hot_values[2] = '0;
      hot_values[3] = -32'sd1;
      hot_values[4] = 32'sd1;
      hot_values[5] = $urandom();
      hot_values[6] = $urandom();
      hot_values[7] = $urandom();
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // empty list, bad positions, extremes, tail removal
      send_command(CMD_READ,   '0, 5'd1);
      send_command(CMD_DELETE, '0, 5'd1);
      send_command(CMD_SEARCH, '0, 5'd0);
      send_command(CMD_INSERT, 32'sd5, 5'd0);
      send_command(CMD_INSERT, 32'sd5, 5'd2);
      send_command(CMD_INSERT, 32'sh7fff_ffff, 5'd1);
      send_command(CMD_INSERT, 32'sh8000_0000, 5'd2);
      send_command(CMD_INSERT, '0, 5'd1);
      send_command(CMD_INSERT, -32'sd1, 5'd2);
      send_command(CMD_READ,   '0, 5'd1);
      send_command(CMD_READ,   '0, 5'd4);
      send_command(CMD_READ,   '0, 5'd5);
      send_command(CMD_READ,   '0, 5'd0);
      send_command(CMD_SEARCH, 32'sh8000_0000, 5'd31);
      send_command(CMD_SEARCH, 32'sd12345, 5'd1);
      send_command(CMD_DELETE, '0, 5'd4);
      send_command(CMD_READ,   '0, 5'd3);
      send_command(CMD_DELETE, '0, 5'd0);
      send_command(CMD_DELETE, '0, 5'd31);
      send_command(CMD_DELETE, '0, 5'd1);
      send_command(CMD_INSERT, 32'sh5555_aaaa, 5'd31);
      send_command(CMD_SEARCH, 32'sh7fff_ffff, 5'd1);

      for (int n = 0; n < RANDOM_BEATS; n++) begin
         calm = (n >= 800 && n < 1100);
         if (n == 500) begin
            @(negedge clock);
            req_valid <= 1'b0;
            while (pending != 0)
               @(negedge clock);
         end
         send_random((n / 120) % 4);
      end

      @(negedge clock);
      req_valid <= 1'b0;
      while (pending != 0)
         @(posedge clock);
      repeat (50) @(posedge clock);
      if (errors == 0 && pending == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

[sim.f]
hdl/ple_pkg.sv
hdl/ple_ctrl.sv
hdl/ple_datapath.sv
hdl/positional_list_engine.sv
tb/list_checker.sv
tb/testbench.sv
